FILE: hw/rtl/pse_pkg.sv
// types, codes and limits shared by the panel setting editor
package pse_pkg;

  typedef enum logic [3:0] {
    OP_MODE_KEY  = 4'd0,
    OP_FREQ_KEY  = 4'd1,
    OP_DUTY_KEY  = 4'd2,
    OP_COUNT_KEY = 4'd3,
    OP_LEVEL_KEY = 4'd4,
    OP_ENC_DOWN  = 4'd5,
    OP_ENC_UP    = 4'd6,
    OP_PUSH      = 4'd7,
    OP_OTHER     = 4'd8,
    OP_WRITE     = 4'd9
  } op_e;

  typedef enum logic [2:0] {
    SEL_NONE  = 3'd0,
    SEL_PULSE = 3'd1,
    SEL_PAUSE = 3'd2,
    SEL_LEVEL = 3'd3,
    SEL_FREQ  = 3'd4,
    SEL_COUNT = 3'd5,
    SEL_DUTY  = 3'd6
  } sel_e;

  localparam int unsigned ValW  = 20;
  localparam int unsigned StepW = 21;
  localparam int unsigned FreqW = 17;
  localparam int unsigned DutyW = 7;
  localparam int unsigned LvlW  = 9;
  localparam int unsigned CntW  = 10;

  localparam logic [ValW-1:0] MaxPulse = 20'd999999;
  localparam logic [ValW-1:0] MaxPause = 20'd999999;
  localparam logic [ValW-1:0] MaxLevel = 20'd99;
  localparam logic [ValW-1:0] MaxFreq  = 20'd99999;
  localparam logic [ValW-1:0] MaxCount = 20'd999;
  localparam logic [ValW-1:0] MaxDuty  = 20'd99;

  localparam logic [ValW-1:0]  RstPulse = 20'd1000;
  localparam logic [ValW-1:0]  RstPause = 20'd1000;
  localparam logic [FreqW-1:0] RstFreq  = 17'd1000;
  localparam logic [DutyW-1:0] RstDuty  = 7'd50;
  localparam logic [LvlW-1:0]  RstLevel = 9'd340;
  localparam logic [CntW-1:0]  RstCount = 10'd0;

  typedef struct packed {
    op_e             op;
    sel_e            sel;
    logic [ValW-1:0] value;
  } item_t;

  typedef struct packed {
    logic             running;
    logic             pulse_mode;
    sel_e             editing;
    logic [StepW-1:0] step;
    logic [ValW-1:0]  pulse;
    logic [ValW-1:0]  pause;
    logic [FreqW-1:0] freq;
    logic [DutyW-1:0] duty;
    logic [LvlW-1:0]  level;
    logic [CntW-1:0]  count;
  } snap_t;

  // true for the six real settings
  function automatic logic sel_valid(sel_e sel);
    logic ok;
    ok = 1'b0;
    unique case (sel)
      SEL_PULSE, SEL_PAUSE, SEL_LEVEL, SEL_FREQ, SEL_COUNT, SEL_DUTY: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic [ValW-1:0] max_of(sel_e sel);
    logic [ValW-1:0] mx;
    mx = '0;
    unique case (sel)
      SEL_PULSE: mx = MaxPulse;
      SEL_PAUSE: mx = MaxPause;
      SEL_LEVEL: mx = MaxLevel;
      SEL_FREQ:  mx = MaxFreq;
      SEL_COUNT: mx = MaxCount;
      SEL_DUTY:  mx = MaxDuty;
      default:   mx = '0;
    endcase
    return mx;
  endfunction

endpackage

FILE: hw/rtl/pse_editor.sv
// setting registers and the combinational next-state logic of the editor
module pse_editor
  import pse_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  item_t item_i,
  output snap_t snap_o
);

  snap_t            state_q, state_d;
  logic             key_hit;
  sel_e             key_sel;
  logic [ValW-1:0]  key_max;
  logic [StepW-1:0] step_x10;
  logic [ValW-1:0]  cur;
  logic [ValW-1:0]  cur_max;
  logic             cur_ok;
  logic [ValW+1:0]  up_sum;
  logic             up_ok;
  logic             down_ok;
  logic [ValW-1:0]  down_val;
  logic             wr_en;
  sel_e             wr_sel;
  logic [ValW-1:0]  wr_val;

  // value of the setting under edit
  always_comb begin
    cur = '0;
    unique case (state_q.editing)
      SEL_PULSE: cur = state_q.pulse;
      SEL_PAUSE: cur = state_q.pause;
      SEL_LEVEL: cur = {{(ValW-LvlW){1'b0}}, state_q.level};
      SEL_FREQ:  cur = {{(ValW-FreqW){1'b0}}, state_q.freq};
      SEL_COUNT: cur = {{(ValW-CntW){1'b0}}, state_q.count};
      SEL_DUTY:  cur = {{(ValW-DutyW){1'b0}}, state_q.duty};
      default:   cur = '0;
    endcase
  end

  assign cur_ok   = sel_valid(state_q.editing);
  assign cur_max  = max_of(state_q.editing);
  assign up_sum   = {2'b00, cur} + {1'b0, state_q.step};
  assign up_ok    = cur_ok && (up_sum <= {2'b00, cur_max});
  // step <= value and value - step >= 1 together mean step < value
  assign down_ok  = cur_ok && ({1'b0, cur} > state_q.step);
  assign down_val = cur - state_q.step[ValW-1:0];
  assign step_x10 = {state_q.step[StepW-4:0], 3'b000} + {state_q.step[StepW-2:0], 1'b0};
  assign key_max  = max_of(key_sel);

  always_comb begin
    key_hit = 1'b0;
    key_sel = SEL_NONE;
    unique case (item_i.op)
      OP_FREQ_KEY: begin
        key_hit = 1'b1;
        key_sel = state_q.pulse_mode ? SEL_PULSE : SEL_FREQ;
      end
      OP_DUTY_KEY: begin
        key_hit = 1'b1;
        key_sel = state_q.pulse_mode ? SEL_PAUSE : SEL_DUTY;
      end
      OP_COUNT_KEY: begin
        key_hit = state_q.pulse_mode;
        key_sel = SEL_COUNT;
      end
      OP_LEVEL_KEY: begin
        key_hit = 1'b1;
        key_sel = SEL_LEVEL;
      end
      default: begin
        key_hit = 1'b0;
        key_sel = SEL_NONE;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    wr_en   = 1'b0;
    wr_sel  = state_q.editing;
    wr_val  = item_i.value;

    // encoder and direct write leave the run flag alone, push toggles it
    if (item_i.op != OP_ENC_DOWN && item_i.op != OP_ENC_UP &&
        item_i.op != OP_PUSH && item_i.op != OP_WRITE) begin
      state_d.running = 1'b0;
    end

    unique case (item_i.op)
      OP_MODE_KEY: begin
        state_d.pulse_mode = ~state_q.pulse_mode;
        state_d.editing    = SEL_NONE;
      end
      OP_ENC_DOWN: begin
        wr_en  = down_ok;
        wr_val = down_val;
      end
      OP_ENC_UP: begin
        wr_en  = up_ok;
        wr_val = up_sum[ValW-1:0];
      end
      OP_PUSH: begin
        state_d.editing = SEL_NONE;
        state_d.running = ~state_q.running;
      end
      OP_WRITE: begin
        wr_sel = item_i.sel;
        wr_en  = sel_valid(item_i.sel) && (item_i.value < max_of(item_i.sel));
      end
      default: begin
      end
    endcase

    if (key_hit) begin
      if (state_q.step > {1'b0, key_max}) begin
        state_d.editing = SEL_NONE;
        state_d.step    = '0;
      end else if (state_q.editing != key_sel) begin
        state_d.editing = key_sel;
        state_d.step    = StepW'(1);
      end else begin
        state_d.step = step_x10;
      end
    end

    if (wr_en) begin
      unique case (wr_sel)
        SEL_PULSE: state_d.pulse = wr_val;
        SEL_PAUSE: state_d.pause = wr_val;
        SEL_LEVEL: state_d.level = wr_val[LvlW-1:0];
        SEL_FREQ:  state_d.freq  = wr_val[FreqW-1:0];
        SEL_COUNT: state_d.count = wr_val[CntW-1:0];
        SEL_DUTY:  state_d.duty  = wr_val[DutyW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.running    <= 1'b0;
      state_q.pulse_mode <= 1'b0;
      state_q.editing    <= SEL_NONE;
      state_q.step       <= '0;
      state_q.pulse      <= RstPulse;
      state_q.pause      <= RstPause;
      state_q.freq       <= RstFreq;
      state_q.duty       <= RstDuty;
      state_q.level      <= RstLevel;
      state_q.count      <= RstCount;
    end else if (en_i) begin
      state_q <= state_d;
    end
  end

  assign snap_o = state_d;

endmodule

FILE: hw/rtl/panel_setting_editor_top.sv
// top level of the panel setting editor: input register, editor, result register
//
// The editor takes one front-panel event per transfer on the slave stream and returns
// one transfer on the master stream holding every setting as it stands after that
// event. Events are key presses (mode, frequency, duty, count, level), encoder moves,
// push and direct writes. It sustains one event per clock cycle while the result
// stream is not stalled: an event sits in the input register while the combinational
// next-state logic on the setting registers works it out, and its snapshot lands in
// the result register at the same edge the settings update, from where it is offered
// on the master stream. The input register can still take one more event while a
// finished result waits to be taken; only a full input register behind a stalled
// result register holds s_axis_tready_o low. After reset the generator is stopped,
// in PWM mode, with nothing under edit, a step of zero, pulse and pause of 1000,
// frequency 1000, duty 50, level 340 and a count of zero.
module panel_setting_editor_top
  import pse_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // event stream
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [23:0]  s_axis_tdata_i,   // new_value [19:0], zero [23:20]
  input  logic [7:0]   s_axis_tuser_i,   // operation [3:0], setting_select [6:4], zero [7]
  // settings snapshot stream
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [111:0] m_axis_tdata_o    // running [0], pulse_mode [1], editing [4:2],
                                         // step_size [24:5], pulse_width [44:25],
                                         // pause_width [64:45], freq_value [81:65],
                                         // duty_value [88:82], level_value [97:89],
                                         // count_value [107:98], zero [111:108]
);

  logic  in_valid_q;
  item_t in_item_q;
  logic  out_valid_q;
  snap_t out_snap_q;
  snap_t snap;
  logic  advance;

  // the event in the input register moves on when the result register is free
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_item_q.op    <= op_e'(s_axis_tuser_i[3:0]);
      in_item_q.sel   <= sel_e'(s_axis_tuser_i[6:4]);
      in_item_q.value <= s_axis_tdata_i[ValW-1:0];
    end
  end

  pse_editor u_editor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (in_item_q),
    .snap_o (snap)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_snap_q <= snap;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000,
                            out_snap_q.count,
                            out_snap_q.level,
                            out_snap_q.duty,
                            out_snap_q.freq,
                            out_snap_q.pause,
                            out_snap_q.pulse,
                            out_snap_q.step[ValW-1:0],
                            out_snap_q.editing,
                            out_snap_q.pulse_mode,
                            out_snap_q.running};

endmodule

FILE: hw/rtl/pse_checker.sv
// port-level checks for the panel setting editor and their bind
module pse_checker
  import pse_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [111:0] m_axis_tdata_o
);

  logic [19:0] step;
  logic [2:0]  editing;

  assign step    = m_axis_tdata_o[24:5];
  assign editing = m_axis_tdata_o[4:2];

  // a stalled result keeps its transfer pending unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // an event taken on an idle block is followed by an offered result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && !m_axis_tvalid_o |=> ##1 m_axis_tvalid_o)
    else $error("result missing after event");

  // step is zero or a power of ten up to a million
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (step == 20'd0 || step == 20'd1 || step == 20'd10 ||
                         step == 20'd100 || step == 20'd1000 || step == 20'd10000 ||
                         step == 20'd100000 || step == 20'd1000000))
    else $error("step not a decimal power");

  // a selected setting always has a non-zero step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && editing != SEL_NONE |-> step != 20'd0 && editing <= SEL_DUTY)
    else $error("selection without step");

endmodule

bind panel_setting_editor_top pse_checker u_pse_checker (.*);
